// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define WPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held
`define WPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/wpr_pkg.sv =====
// Shared constants and types for the Williams percent R block.
// No dependencies; imported by the top level and its checker.
package wpr_pkg;

  localparam int PRICE_BITS   = 32;
  localparam int WINDOW_DEPTH = 64;
  localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
  localparam int LEN_BITS     = $clog2(WINDOW_DEPTH + 1);
  localparam int PCT_BITS     = 15;
  localparam int PROD_BITS    = PRICE_BITS + PCT_BITS;
  localparam int DIVCNT_BITS  = $clog2(PCT_BITS);
  localparam int IN_DATA_BITS = 3 * PRICE_BITS;
  localparam int OUT_DATA_BITS = ((PCT_BITS + 7) / 8) * 8;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [PCT_BITS-1:0] PCT_FULL_SCALE = PCT_BITS'(25600);
  localparam logic [LEN_BITS-1:0] WLEN_RESET     = LEN_BITS'(10);

  // register indexes (byte address / 4)
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DIV,
    S_OUT
  } wpr_state_t;

endpackage

// ===== src/williams_percent_r.sv =====
// Williams percent R over a sliding window of price bars.
// Depends on wpr_pkg for widths, constants and the state type.

// A bar that gives no result (the first window_length bars) is taken without
// leaving the idle state. A bar that gives a result holds off the next bar
// until its result is loaded into the output register. The window highs
// and lows sit in one synchronous ring memory with a single read port, so the
// max/min scan reads one older entry per cycle, window_length - 1 reads in all.
// The calc state then forms (max - close) * 25600, a bit-serial divider forms
// the 15 quotient bits, and the output register is loaded. A window of one bar
// reads nothing. When the window is flat, or the close lies at or beyond a
// window extreme, the divider is skipped. An earlier result that is still
// unread holds the load until it is taken. Once the output register is loaded,
// the next bar is taken while that result is still unread.
// window_length 0 acts as 1, and values above 64 act as 64. flat_range is set,
// and percent_r is 0, when the window high equals the window low.
module williams_percent_r (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: bar_high [31:0], bar_low [63:32], bar_close [95:64]
  input  logic [wpr_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: percent_r [14:0], zero [15]
  output logic [wpr_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  // out_tuser: flat_range [0]
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [wpr_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import wpr_pkg::*;

  wpr_state_t state_r, state_nxt;

  logic [LEN_BITS-1:0]   window_length_r;
  logic [LEN_BITS-1:0]   eff_len;
  logic [LEN_BITS-1:0]   bars_clamped;
  logic [LEN_BITS-1:0]   bars_seen_r;
  logic [SLOT_BITS-1:0]  write_slot_r;
  logic                  emit;

  logic [PRICE_BITS-1:0] bar_high, bar_low, bar_close;
  logic                  in_accept;
  logic                  cfg_write;

  logic [2*PRICE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [2*PRICE_BITS-1:0] rd_data_r;
  logic                    rd_vld_r;
  logic                    rd_en;
  logic [SLOT_BITS-1:0]    scan_addr_r;
  logic [SLOT_BITS-1:0]    scan_cnt_r;
  logic                    scan_done;

  logic [PRICE_BITS-1:0] max_r, min_r, close_r;
  logic [PRICE_BITS-1:0] rd_high, rd_low;

  logic                  is_flat, close_top, close_bottom, calc_direct;
  logic [PROD_BITS-1:0]  prod;
  logic [PRICE_BITS-1:0] den_r, rem_r;
  logic [PCT_BITS-1:0]   num_lo_r;
  logic [PCT_BITS-1:0]   quot_r;
  logic                  flat_r;
  logic [DIVCNT_BITS-1:0] div_cnt_r;
  logic [PRICE_BITS:0]   div_trial, div_sub;
  logic                  div_ge;

  logic                  load_out;
  logic [PCT_BITS-1:0]   out_pct_r;
  logic                  out_flat_r;
  logic                  out_tvalid_r;

  assign bar_high  = in_tdata[PRICE_BITS-1:0];
  assign bar_low   = in_tdata[2*PRICE_BITS-1:PRICE_BITS];
  assign bar_close = in_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
  assign in_accept = in_tvalid && in_tready;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_BITS-1] == REG_WINDOW_LENGTH) begin
      cfg_prdata = 32'(window_length_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WLEN_RESET;
    end else if (cfg_write && cfg_paddr[CFG_ADDR_BITS-1] == REG_WINDOW_LENGTH) begin
      window_length_r <= cfg_pwdata[LEN_BITS-1:0];
    end
  end

  // ---------------- window bookkeeping ----------------
  always_comb begin
    if (window_length_r == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (window_length_r > LEN_BITS'(WINDOW_DEPTH)) begin
      eff_len = LEN_BITS'(WINDOW_DEPTH);
    end else begin
      eff_len = window_length_r;
    end
    bars_clamped = (bars_seen_r > eff_len) ? eff_len : bars_seen_r;
    emit         = (bars_clamped == eff_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      bars_seen_r  <= '0;
    end else if (in_accept) begin
      write_slot_r <= write_slot_r + SLOT_BITS'(1);
      bars_seen_r  <= emit ? bars_clamped : bars_clamped + LEN_BITS'(1);
    end
  end

  // ---------------- ring memory ----------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_mem[write_slot_r] <= {bar_low, bar_high};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_mem[scan_addr_r];
    end
  end

  assign rd_high   = rd_data_r[PRICE_BITS-1:0];
  assign rd_low    = rd_data_r[2*PRICE_BITS-1:PRICE_BITS];
  assign scan_done = (scan_cnt_r == '0) && !rd_vld_r;

  // ---------------- arithmetic ----------------
  always_comb begin
    is_flat      = (max_r == min_r);
    close_top    = (close_r >= max_r);
    // close at or below the low: quotient reaches full scale
    close_bottom = (close_r <= min_r);
    calc_direct  = is_flat || close_top || close_bottom;
    prod         = PROD_BITS'(max_r - close_r) * PROD_BITS'(PCT_FULL_SCALE);
    div_trial    = {rem_r, num_lo_r[PCT_BITS-1]};
    div_sub      = div_trial - {1'b0, den_r};
    div_ge       = (div_trial >= {1'b0, den_r});
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && emit) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = calc_direct ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_cnt_r == '0) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_SCAN: rd_en = (scan_cnt_r != '0);
      S_OUT:  load_out = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept && emit) begin
          // newest bar seeds the extremes; scan the older ones
          max_r       <= bar_high;
          min_r       <= bar_low;
          close_r     <= bar_close;
          scan_addr_r <= write_slot_r - SLOT_BITS'(1);
          scan_cnt_r  <= SLOT_BITS'(eff_len - LEN_BITS'(1));
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          scan_addr_r <= scan_addr_r - SLOT_BITS'(1);
          scan_cnt_r  <= scan_cnt_r - SLOT_BITS'(1);
        end
        if (rd_vld_r) begin
          if (rd_high > max_r) max_r <= rd_high;
          if (rd_low < min_r)  min_r <= rd_low;
        end
      end
      S_CALC: begin
        flat_r    <= is_flat;
        den_r     <= max_r - min_r;
        rem_r     <= prod[PROD_BITS-1:PCT_BITS];
        num_lo_r  <= prod[PCT_BITS-1:0];
        div_cnt_r <= DIVCNT_BITS'(PCT_BITS - 1);
        if (is_flat || close_top) begin
          quot_r <= '0;
        end else begin
          quot_r <= PCT_FULL_SCALE;
        end
      end
      S_DIV: begin
        rem_r     <= div_ge ? div_sub[PRICE_BITS-1:0] : div_trial[PRICE_BITS-1:0];
        num_lo_r  <= {num_lo_r[PCT_BITS-2:0], 1'b0};
        quot_r    <= {quot_r[PCT_BITS-2:0], div_ge};
        div_cnt_r <= div_cnt_r - DIVCNT_BITS'(1);
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pct_r  <= quot_r;
      out_flat_r <= flat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_pct_r);
  assign out_tuser  = out_flat_r;

endmodule

// ===== src/wpr_checker.sv =====
// Port-level checker for williams_percent_r, bound to the top level.
// Depends on wpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wpr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [wpr_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic                              cfg_pready
);
  import wpr_pkg::*;

  `WPR_ASSERT_NOW(a_pct_range, clk, rst_n, out_tvalid, out_tdata[PCT_BITS-1:0] <= PCT_FULL_SCALE)
  `WPR_ASSERT_NOW(a_flat_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `WPR_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid))
  `WPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `WPR_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind williams_percent_r wpr_checker u_wpr_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for williams_percent_r: streams price bars in, predicts
// percent R for each window and compares every result as it leaves the block.
// Depends on wpr_pkg and the williams_percent_r top level; nothing else.
module tb_top;
  import wpr_pkg::*;

  localparam int SETTLE_CYCLES = 90;
  localparam int TAIL_CYCLES   = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [PCT_BITS-1:0] percent_r;
    logic                flat_range;
  } pct_result_t;

  logic                     clk;
  logic                     rst_n;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0]              cfg_pwdata;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  williams_percent_r dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state: own copy of the rings, write pointer, fill count and setting
  logic [PRICE_BITS-1:0] high_hist [WINDOW_DEPTH];
  logic [PRICE_BITS-1:0] low_hist  [WINDOW_DEPTH];
  int unsigned           next_slot;
  int unsigned           bars_held;
  logic [6:0]            window_setting;

  pct_result_t pending_results [$];
  int unsigned mismatches;
  int unsigned bars_sent;
  int unsigned results_checked;
  int unsigned flat_results;
  int unsigned settings_written;
  int unsigned quiet_cycles;
  bit          no_idle;
  logic [31:0] trend_price;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned span_of(input logic [6:0] setting);
    if (setting == 7'd0) return 1;
    if (setting > WINDOW_DEPTH) return WINDOW_DEPTH;
    return setting;
  endfunction

  task automatic predict_percent_r(input logic [31:0] hi, input logic [31:0] lo,
                                   input logic [31:0] cl, output bit produced,
                                   output pct_result_t res);
    int unsigned span;
    int unsigned slot;
    int unsigned k;
    logic [31:0] top;
    logic [31:0] bottom;
    logic [63:0] ratio;
    span = span_of(window_setting);
    if (bars_held > span) bars_held = span;
    produced = (bars_held >= span);
    high_hist[next_slot] = hi;
    low_hist[next_slot]  = lo;
    next_slot = (next_slot + 1) % WINDOW_DEPTH;
    res = '0;
    if (!produced) begin
      bars_held++;
    end else begin
      top = '0;
      bottom = '1;
      slot = next_slot;
      for (k = 0; k < span; k++) begin
        slot = (slot == 0) ? WINDOW_DEPTH - 1 : slot - 1;
        if (high_hist[slot] > top) top = high_hist[slot];
        if (low_hist[slot] < bottom) bottom = low_hist[slot];
      end
      if (top == bottom) begin
        res.flat_range = 1'b1;
      end else if (cl >= top) begin
        res.percent_r = '0;
      end else if (top < bottom) begin
        // window low above window high with close below the high: beyond 100
        res.percent_r = PCT_FULL_SCALE;
      end else begin
        ratio = (64'(top - cl) * 64'd25600) / 64'(top - bottom);
        if (ratio > 64'(PCT_FULL_SCALE)) ratio = 64'(PCT_FULL_SCALE);
        res.percent_r = ratio[PCT_BITS-1:0];
      end
    end
  endtask

  task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                          input logic [31:0] cl);
    bit          produced;
    pct_result_t res;
    if (!no_idle) begin
      while ($urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata  <= {cl, lo, hi};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_percent_r(hi, lo, cl, produced, res);
    if (produced) pending_results.push_back(res);
    bars_sent++;
  endtask

  // Hold the input and wait until every predicted result has been taken
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_window_length(input logic [6:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_BITS'({REG_WINDOW_LENGTH, 2'b00});
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    window_setting = value;
    settings_written++;
  endtask

  // Mostly a drifting market with sane bars; some flat bars, some closes
  // outside the bar and some fully random fields
  task automatic make_bar(input int unsigned flat_pct, output logic [31:0] hi,
                          output logic [31:0] lo, output logic [31:0] cl);
    int unsigned pick;
    int unsigned spread;
    pick = $urandom_range(99);
    if (pick < flat_pct) begin
      hi = trend_price;
      lo = trend_price;
      cl = trend_price;
    end else if (pick < flat_pct + 20) begin
      hi = $urandom;
      lo = $urandom;
      cl = $urandom;
    end else begin
      trend_price += $urandom_range(400);
      trend_price -= 200;
      if (trend_price < 32'd50_000_000) trend_price += 32'd50_000_000;
      spread = ($urandom_range(9) == 0) ? $urandom_range(1 << 24) : $urandom_range(300);
      hi = trend_price + $urandom_range(spread);
      lo = trend_price - $urandom_range(spread);
      case ($urandom_range(9))
        0:       cl = hi + $urandom_range(500, 1);
        1:       cl = lo - $urandom_range(500, 1);
        default: cl = lo + $urandom_range(hi - lo);
      endcase
    end
  endtask

  task automatic run_phase(input logic [6:0] setting, input int unsigned count,
                           input int unsigned flat_pct, input bit steady);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cl;
    int unsigned i;
    write_window_length(setting);
    no_idle = steady;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      make_bar(flat_pct, hi, lo, cl);
      send_bar(hi, lo, cl);
    end
    no_idle = 1'b0;
  endtask

  // Reset length of ten: ten quiet bars, then one result
  task automatic test_default_window();
    int unsigned i;
    for (i = 0; i < 11; i++) send_bar(1000 + 7 * i, 900 + 3 * i, 950 + 5 * i);
  endtask

  task automatic test_price_extremes();
    write_window_length(7'd2);
    send_bar(32'd0, 32'd0, 32'd0);
    send_bar(32'd0, 32'd0, 32'd0);
    send_bar(PRICE_MAX, 32'd0, 32'd0);
    send_bar(PRICE_MAX, 32'd0, PRICE_MAX);
    send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);
    send_bar(PRICE_MAX, PRICE_MAX, 32'd0);
    send_bar(32'd5, 32'd9, 32'd7);
    send_bar(32'd3, 32'd8, 32'd2);
    send_bar(32'd3, 32'd8, 32'd6);
    send_bar(32'd1000, 32'd200, 32'd600);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
  endtask

  // A length of zero acts as one
  task automatic test_zero_window();
    write_window_length(7'd0);
    send_bar(32'd7, 32'd3, 32'd5);
    send_bar(32'd7, 32'd7, 32'd7);
    send_bar(PRICE_MAX, 32'd0, 32'd1);
    send_bar(32'd2, 32'd1, 32'd2);
  endtask

  task automatic test_long_windows();
    run_phase(7'd64, 250, 5, 1'b0);
    run_phase(7'd127, 150, 5, 1'b0);
    run_phase(7'd100, 150, 5, 1'b0);
  endtask

  // Lowering the length must give results at once
  task automatic test_short_windows();
    run_phase(7'd5, 200, 15, 1'b1);
    run_phase(7'd1, 150, 30, 1'b0);
    run_phase(7'd3, 150, 30, 1'b0);
  endtask

  task automatic test_mixed_lengths();
    run_phase(7'($urandom_range(63, 2)), 250, 10, 1'b0);
    run_phase(7'd10, 100, 10, 1'b0);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tvalid   <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    next_slot        = 0;
    bars_held        = 0;
    window_setting   = 7'd10;
    mismatches       = 0;
    bars_sent        = 0;
    results_checked  = 0;
    flat_results     = 0;
    settings_written = 0;
    no_idle          = 1'b0;
    trend_price      = 32'h4000_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_price_extremes();
    test_zero_window();
    test_long_windows();
    test_short_windows();
    test_mixed_lengths();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bars under %0d window length writes (0, 1, 2..64, 100, 127)",
             bars_sent, settings_written);
    $display("Checked %0d results, %0d of them over a flat range; %0d left unmatched",
             results_checked, flat_results, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin : check_result
    pct_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (out_tuser) flat_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result percent_r=%0d flat_range=%0b", $time,
                 out_tdata[PCT_BITS-1:0], out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[PCT_BITS-1:0] !== want.percent_r) begin
          $display("%0t: percent_r expected %0d actual %0d", $time, want.percent_r,
                   out_tdata[PCT_BITS-1:0]);
          mismatches++;
        end
        if (out_tuser !== want.flat_range) begin
          $display("%0t: flat_range expected %0b actual %0b", $time, want.flat_range,
                   out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which no request, result or register write moves
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
